[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[src/rv32d_pkg.sv]
package rv32d_pkg;

    localparam int WORD_BITS  = 32;
    localparam int SHAMT_BITS = $clog2(WORD_BITS);
    localparam int KIND_BITS  = 6;
    localparam int REG_BITS   = 5;
    localparam int CSR_BITS   = 12;

    // major opcodes, bits 6..0
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_ALUI   = 7'h13;
    localparam logic [6:0] OPC_ALUR   = 7'h33;
    localparam logic [6:0] OPC_SYS    = 7'h73;

    localparam logic [2:0] F3_ZERO  = 3'd0;
    localparam logic [2:0] F3_SLL   = 3'd1;
    localparam logic [2:0] F3_SR    = 3'd5;
    localparam logic [6:0] F7_ZERO  = 7'h00;
    localparam logic [6:0] F7_ALT   = 7'h20;

    localparam logic [WORD_BITS-1:0] ECALL_WORD  = 32'h0000_0073;
    localparam logic [WORD_BITS-1:0] EBREAK_WORD = 32'h0010_0073;

    typedef enum logic [3:0] {
        FMT_NONE,
        FMT_LUI,
        FMT_AUIPC,
        FMT_JAL,
        FMT_JALR,
        FMT_BRANCH,
        FMT_LOAD,
        FMT_STORE,
        FMT_ALUI,
        FMT_ALUR,
        FMT_SYS
    } t_fmt;

    typedef enum logic [KIND_BITS-1:0] {
        OP_ILLEGAL = 6'd0,
        OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
        OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
        OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU,
        OP_SB, OP_SH, OP_SW,
        OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI,
        OP_SLLI, OP_SRLI, OP_SRAI,
        OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
        OP_ECALL, OP_EBREAK,
        OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI
    } t_op_kind;

    function automatic t_op_kind branch_kind(input logic [2:0] f3);
        t_op_kind k;
        unique case (f3)
            3'd0:    k = OP_BEQ;
            3'd1:    k = OP_BNE;
            3'd4:    k = OP_BLT;
            3'd5:    k = OP_BGE;
            3'd6:    k = OP_BLTU;
            3'd7:    k = OP_BGEU;
            default: k = OP_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic t_op_kind load_kind(input logic [2:0] f3);
        t_op_kind k;
        unique case (f3)
            3'd0:    k = OP_LB;
            3'd1:    k = OP_LH;
            3'd2:    k = OP_LW;
            3'd4:    k = OP_LBU;
            3'd5:    k = OP_LHU;
            default: k = OP_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic t_op_kind store_kind(input logic [2:0] f3);
        t_op_kind k;
        unique case (f3)
            3'd0:    k = OP_SB;
            3'd1:    k = OP_SH;
            3'd2:    k = OP_SW;
            default: k = OP_ILLEGAL;
        endcase
        return k;
    endfunction

    // shift codes (1 and 5) are handled by the caller
    function automatic t_op_kind alui_kind(input logic [2:0] f3);
        t_op_kind k;
        unique case (f3)
            3'd0:    k = OP_ADDI;
            3'd2:    k = OP_SLTI;
            3'd3:    k = OP_SLTIU;
            3'd4:    k = OP_XORI;
            3'd6:    k = OP_ORI;
            3'd7:    k = OP_ANDI;
            default: k = OP_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic t_op_kind alur_kind(input logic [2:0] f3);
        t_op_kind k;
        unique case (f3)
            3'd0:    k = OP_ADD;
            3'd1:    k = OP_SLL;
            3'd2:    k = OP_SLT;
            3'd3:    k = OP_SLTU;
            3'd4:    k = OP_XOR;
            3'd5:    k = OP_SRL;
            3'd6:    k = OP_OR;
            default: k = OP_AND;
        endcase
        return k;
    endfunction

    function automatic t_op_kind csr_kind(input logic [2:0] f3);
        t_op_kind k;
        unique case (f3)
            3'd1:    k = OP_CSRRW;
            3'd2:    k = OP_CSRRS;
            3'd3:    k = OP_CSRRC;
            3'd5:    k = OP_CSRRWI;
            3'd6:    k = OP_CSRRSI;
            3'd7:    k = OP_CSRRCI;
            default: k = OP_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage

[src/rv32i_instruction_decoder.sv]
// RV32I instruction decoder. Each request carries one instruction word and its
// byte address. The result names the instruction (op kind 1..45, or 0 with the
// illegal flag for anything unrecognized), its rd/rs1/rs2 fields, the
// sign-extended immediate of its format (shift amount for slli/srli/srai), the
// CSR number, and pc + immediate for branches and jal. Fields an instruction
// does not use read as zero, and an illegal word gives all-zero fields. The
// block is a three-register pipeline: input capture with opcode class, field
// decode, then target add and cleanup into the output register. It takes one
// request per clock while o_in_stall is low. A request moves through the
// capture, decode and output registers in order, and its result is taken
// while the output is not stalled. Output stall ripples back through the stage
// enables: a bubble anywhere in the pipe is filled, and the input stalls only
// when all three stages hold requests and the output is stalled.
`include "assert_macros.svh"

module rv32i_instruction_decoder (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    // request channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [rv32d_pkg::WORD_BITS-1:0]        i_pc,
    input  logic [rv32d_pkg::WORD_BITS-1:0]        i_word,

    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [rv32d_pkg::KIND_BITS-1:0]        o_op_kind,
    output logic                                   o_illegal,
    output logic [rv32d_pkg::REG_BITS-1:0]         o_dest_reg,
    output logic [rv32d_pkg::REG_BITS-1:0]         o_src_reg_a,
    output logic [rv32d_pkg::REG_BITS-1:0]         o_src_reg_b,
    output logic signed [rv32d_pkg::WORD_BITS-1:0] o_immediate,
    output logic [rv32d_pkg::CSR_BITS-1:0]         o_csr_number,
    output logic [rv32d_pkg::WORD_BITS-1:0]        o_target
);

    localparam int WB = rv32d_pkg::WORD_BITS;
    localparam int RB = rv32d_pkg::REG_BITS;
    localparam int CB = rv32d_pkg::CSR_BITS;
    localparam int SB = rv32d_pkg::SHAMT_BITS;

    // ---------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or the one after
    // it is moving. The output register moves when it is empty or taken.
    // ---------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3 = !r_v3 || !i_out_stall;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: capture the request and classify the major opcode.
    // ---------------------------------------------------------------
    rv32d_pkg::t_fmt       n_s1_fmt;
    rv32d_pkg::t_fmt       r_s1_fmt;
    logic [WB-1:0]         r_s1_pc;
    logic [WB-1:0]         r_s1_word;

    always_comb begin
        unique case (i_word[6:0])
            rv32d_pkg::OPC_LUI:    n_s1_fmt = rv32d_pkg::FMT_LUI;
            rv32d_pkg::OPC_AUIPC:  n_s1_fmt = rv32d_pkg::FMT_AUIPC;
            rv32d_pkg::OPC_JAL:    n_s1_fmt = rv32d_pkg::FMT_JAL;
            rv32d_pkg::OPC_JALR:   n_s1_fmt = rv32d_pkg::FMT_JALR;
            rv32d_pkg::OPC_BRANCH: n_s1_fmt = rv32d_pkg::FMT_BRANCH;
            rv32d_pkg::OPC_LOAD:   n_s1_fmt = rv32d_pkg::FMT_LOAD;
            rv32d_pkg::OPC_STORE:  n_s1_fmt = rv32d_pkg::FMT_STORE;
            rv32d_pkg::OPC_ALUI:   n_s1_fmt = rv32d_pkg::FMT_ALUI;
            rv32d_pkg::OPC_ALUR:   n_s1_fmt = rv32d_pkg::FMT_ALUR;
            rv32d_pkg::OPC_SYS:    n_s1_fmt = rv32d_pkg::FMT_SYS;
            default:               n_s1_fmt = rv32d_pkg::FMT_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_fmt  <= n_s1_fmt;
            r_s1_pc   <= i_pc;
            r_s1_word <= i_word;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: op kind, register fields and immediate per format.
    // ---------------------------------------------------------------
    logic [2:0]    f3;
    logic [6:0]    f7;
    logic [RB-1:0] fld_rd, fld_rs1, fld_rs2;
    logic [WB-1:0] imm_i, imm_s, imm_b, imm_u, imm_j, imm_sh;

    assign f3      = r_s1_word[14:12];
    assign f7      = r_s1_word[31:25];
    assign fld_rd  = r_s1_word[11:7];
    assign fld_rs1 = r_s1_word[19:15];
    assign fld_rs2 = r_s1_word[24:20];

    assign imm_i  = {{(WB-12){r_s1_word[31]}}, r_s1_word[31:20]};
    assign imm_s  = {{(WB-12){r_s1_word[31]}}, r_s1_word[31:25], r_s1_word[11:7]};
    assign imm_b  = {{(WB-13){r_s1_word[31]}}, r_s1_word[31], r_s1_word[7],
                     r_s1_word[30:25], r_s1_word[11:8], 1'b0};
    assign imm_u  = {r_s1_word[31:12], 12'd0};
    assign imm_j  = {{(WB-21){r_s1_word[31]}}, r_s1_word[31], r_s1_word[19:12],
                     r_s1_word[20], r_s1_word[30:21], 1'b0};
    // shift amount: low bits of the rs2 slot
    assign imm_sh = {{(WB-SB){1'b0}}, r_s1_word[20 +: SB]};

    rv32d_pkg::t_op_kind n_s2_kind, r_s2_kind;
    logic [RB-1:0]       n_s2_rd, n_s2_a, n_s2_b, r_s2_rd, r_s2_a, r_s2_b;
    logic [WB-1:0]       n_s2_imm, r_s2_imm;
    logic [CB-1:0]       n_s2_csr, r_s2_csr;
    logic                n_s2_tgt, r_s2_tgt;
    logic [WB-1:0]       r_s2_pc;

    always_comb begin
        n_s2_kind = rv32d_pkg::OP_ILLEGAL;
        n_s2_rd   = '0;
        n_s2_a    = '0;
        n_s2_b    = '0;
        n_s2_imm  = '0;
        n_s2_csr  = '0;
        n_s2_tgt  = 1'b0;
        unique case (r_s1_fmt)
            rv32d_pkg::FMT_LUI: begin
                n_s2_kind = rv32d_pkg::OP_LUI;
                n_s2_imm  = imm_u;
                n_s2_rd   = fld_rd;
            end
            rv32d_pkg::FMT_AUIPC: begin
                n_s2_kind = rv32d_pkg::OP_AUIPC;
                n_s2_imm  = imm_u;
                n_s2_rd   = fld_rd;
            end
            rv32d_pkg::FMT_JAL: begin
                n_s2_kind = rv32d_pkg::OP_JAL;
                n_s2_imm  = imm_j;
                n_s2_rd   = fld_rd;
                n_s2_tgt  = 1'b1;
            end
            rv32d_pkg::FMT_JALR: begin
                if (f3 == rv32d_pkg::F3_ZERO) begin
                    n_s2_kind = rv32d_pkg::OP_JALR;
                end
                n_s2_imm = imm_i;
                n_s2_rd  = fld_rd;
                n_s2_a   = fld_rs1;
            end
            rv32d_pkg::FMT_BRANCH: begin
                n_s2_kind = rv32d_pkg::branch_kind(f3);
                n_s2_imm  = imm_b;
                n_s2_a    = fld_rs1;
                n_s2_b    = fld_rs2;
                n_s2_tgt  = 1'b1;
            end
            rv32d_pkg::FMT_LOAD: begin
                n_s2_kind = rv32d_pkg::load_kind(f3);
                n_s2_imm  = imm_i;
                n_s2_rd   = fld_rd;
                n_s2_a    = fld_rs1;
            end
            rv32d_pkg::FMT_STORE: begin
                n_s2_kind = rv32d_pkg::store_kind(f3);
                n_s2_imm  = imm_s;
                n_s2_a    = fld_rs1;
                n_s2_b    = fld_rs2;
            end
            rv32d_pkg::FMT_ALUI: begin
                n_s2_rd = fld_rd;
                n_s2_a  = fld_rs1;
                if (f3 == rv32d_pkg::F3_SLL) begin
                    n_s2_imm = imm_sh;
                    if (f7 == rv32d_pkg::F7_ZERO) begin
                        n_s2_kind = rv32d_pkg::OP_SLLI;
                    end
                end else if (f3 == rv32d_pkg::F3_SR) begin
                    n_s2_imm = imm_sh;
                    if (f7 == rv32d_pkg::F7_ZERO) begin
                        n_s2_kind = rv32d_pkg::OP_SRLI;
                    end else if (f7 == rv32d_pkg::F7_ALT) begin
                        n_s2_kind = rv32d_pkg::OP_SRAI;
                    end
                end else begin
                    n_s2_kind = rv32d_pkg::alui_kind(f3);
                    n_s2_imm  = imm_i;
                end
            end
            rv32d_pkg::FMT_ALUR: begin
                n_s2_rd = fld_rd;
                n_s2_a  = fld_rs1;
                n_s2_b  = fld_rs2;
                if (f7 == rv32d_pkg::F7_ZERO) begin
                    n_s2_kind = rv32d_pkg::alur_kind(f3);
                end else if (f7 == rv32d_pkg::F7_ALT && f3 == rv32d_pkg::F3_ZERO) begin
                    n_s2_kind = rv32d_pkg::OP_SUB;
                end else if (f7 == rv32d_pkg::F7_ALT && f3 == rv32d_pkg::F3_SR) begin
                    n_s2_kind = rv32d_pkg::OP_SRA;
                end
            end
            rv32d_pkg::FMT_SYS: begin
                if (f3 == rv32d_pkg::F3_ZERO) begin
                    // only the two exact environment-call words are legal
                    if (r_s1_word == rv32d_pkg::ECALL_WORD) begin
                        n_s2_kind = rv32d_pkg::OP_ECALL;
                    end else if (r_s1_word == rv32d_pkg::EBREAK_WORD) begin
                        n_s2_kind = rv32d_pkg::OP_EBREAK;
                    end
                end else begin
                    n_s2_kind = rv32d_pkg::csr_kind(f3);
                    n_s2_rd   = fld_rd;
                    n_s2_a    = fld_rs1;
                    n_s2_csr  = r_s1_word[31:20];
                end
            end
            default: begin
                n_s2_kind = rv32d_pkg::OP_ILLEGAL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_kind <= n_s2_kind;
            r_s2_rd   <= n_s2_rd;
            r_s2_a    <= n_s2_a;
            r_s2_b    <= n_s2_b;
            r_s2_imm  <= n_s2_imm;
            r_s2_csr  <= n_s2_csr;
            r_s2_tgt  <= n_s2_tgt;
            r_s2_pc   <= r_s1_pc;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: target add, then clear every field of an illegal word.
    // ---------------------------------------------------------------
    logic          ok;
    logic [WB-1:0] n_s3_target;

    assign ok          = (r_s2_kind != rv32d_pkg::OP_ILLEGAL);
    assign n_s3_target = (r_s2_tgt && ok) ? (r_s2_pc + r_s2_imm) : '0;

    rv32d_pkg::t_op_kind r_s3_kind;
    logic                r_s3_illegal;
    logic [RB-1:0]       r_s3_rd, r_s3_a, r_s3_b;
    logic [WB-1:0]       r_s3_imm, r_s3_target;
    logic [CB-1:0]       r_s3_csr;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_kind    <= r_s2_kind;
            r_s3_illegal <= !ok;
            r_s3_rd      <= ok ? r_s2_rd  : '0;
            r_s3_a       <= ok ? r_s2_a   : '0;
            r_s3_b       <= ok ? r_s2_b   : '0;
            r_s3_imm     <= ok ? r_s2_imm : '0;
            r_s3_csr     <= ok ? r_s2_csr : '0;
            r_s3_target  <= n_s3_target;
        end
    end

    assign o_out_valid  = r_v3;
    assign o_op_kind    = r_s3_kind;
    assign o_illegal    = r_s3_illegal;
    assign o_dest_reg   = r_s3_rd;
    assign o_src_reg_a  = r_s3_a;
    assign o_src_reg_b  = r_s3_b;
    assign o_immediate  = r_s3_imm;
    assign o_csr_number = r_s3_csr;
    assign o_target     = r_s3_target;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `ASSERT_IMPLIES(a_illegal_flag, i_clk, i_rst_n, o_out_valid,
        o_illegal == (o_op_kind == rv32d_pkg::OP_ILLEGAL))
    `ASSERT_IMPLIES(a_illegal_zero, i_clk, i_rst_n, o_out_valid && o_illegal,
        o_immediate == '0 && o_target == '0 && o_csr_number == '0 &&
        o_dest_reg == '0)
    `ASSERT_IMPLIES(a_target_only_flow, i_clk, i_rst_n, o_out_valid && o_target != '0,
        o_op_kind == rv32d_pkg::OP_JAL ||
        (o_op_kind >= rv32d_pkg::OP_BEQ && o_op_kind <= rv32d_pkg::OP_BGEU))
    `ASSERT_IMPLIES(a_stall_needs_item, i_clk, i_rst_n, o_in_stall,
        r_v1 && r_v2 && r_v3 && i_out_stall)
    `ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && o_op_kind == $past(o_op_kind) && o_target == $past(o_target))

endmodule

[dv/tb_rv32i_instruction_decoder.sv]
`timescale 1ns / 1ps

module tb_rv32i_instruction_decoder;

    localparam int WORD_BITS  = rv32d_pkg::WORD_BITS;
    localparam int SHAMT_BITS = rv32d_pkg::SHAMT_BITS;
    localparam int KIND_BITS  = rv32d_pkg::KIND_BITS;
    localparam int REG_BITS   = rv32d_pkg::REG_BITS;
    localparam int CSR_BITS   = rv32d_pkg::CSR_BITS;

    localparam int RANDOM_REQUESTS = 1850;
    localparam int DRAIN_LIMIT     = 2000;  // cycles allowed for the pipe to empty
    localparam int SETTLE_CYCLES   = 20;    // extra cycles after the drain before leftovers are flagged

    // funct3 codes, grouped by major opcode
    localparam logic [2:0] F3_BEQ    = 3'd0;
    localparam logic [2:0] F3_BNE    = 3'd1;
    localparam logic [2:0] F3_BLT    = 3'd4;
    localparam logic [2:0] F3_BGE    = 3'd5;
    localparam logic [2:0] F3_BLTU   = 3'd6;
    localparam logic [2:0] F3_BGEU   = 3'd7;
    localparam logic [2:0] F3_BYTE   = 3'd0;
    localparam logic [2:0] F3_HALF   = 3'd1;
    localparam logic [2:0] F3_WORD   = 3'd2;
    localparam logic [2:0] F3_BYTEU  = 3'd4;
    localparam logic [2:0] F3_HALFU  = 3'd5;
    localparam logic [2:0] F3_ADD    = 3'd0;
    localparam logic [2:0] F3_SLT    = 3'd2;
    localparam logic [2:0] F3_SLTU   = 3'd3;
    localparam logic [2:0] F3_XOR    = 3'd4;
    localparam logic [2:0] F3_OR     = 3'd6;
    localparam logic [2:0] F3_AND    = 3'd7;
    localparam logic [2:0] F3_CSRRW  = 3'd1;
    localparam logic [2:0] F3_CSRRS  = 3'd2;
    localparam logic [2:0] F3_CSRRC  = 3'd3;
    localparam logic [2:0] F3_CSRRWI = 3'd5;
    localparam logic [2:0] F3_CSRRSI = 3'd6;
    localparam logic [2:0] F3_CSRRCI = 3'd7;

    typedef struct {
        rv32d_pkg::t_op_kind   kind;
        logic                  illegal;
        logic [REG_BITS-1:0]   rd;
        logic [REG_BITS-1:0]   rs1;
        logic [REG_BITS-1:0]   rs2;
        logic [WORD_BITS-1:0]  imm;
        logic [CSR_BITS-1:0]   csr;
        logic [WORD_BITS-1:0]  target;
    } t_decoded;

    // Holds the decodes of accepted requests, oldest first, and checks results.
    class decode_scoreboard;
        t_decoded pending_decodes[$];
        int       errors;
        int       results_checked;
        bit       kinds_seen[64];

        function new();
            errors          = 0;
            results_checked = 0;
        endfunction

        function t_decoded decode_word(logic [WORD_BITS-1:0] pc, logic [WORD_BITS-1:0] w);
            t_decoded             d;
            rv32d_pkg::t_op_kind  kind;
            logic [6:0]           opc;
            logic [2:0]           f3;
            logic [6:0]           f7;
            logic [WORD_BITS-1:0] imm_i, imm_s, imm_b, imm_u, imm_j;
            opc   = w[6:0];
            f3    = w[14:12];
            f7    = w[31:25];
            imm_i = {{20{w[31]}}, w[31:20]};
            imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
            imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            imm_u = {w[31:12], 12'b0};
            imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            kind     = rv32d_pkg::OP_ILLEGAL;
            d.rd     = '0;
            d.rs1    = '0;
            d.rs2    = '0;
            d.imm    = '0;
            d.csr    = '0;
            d.target = '0;
            case (opc)
                rv32d_pkg::OPC_LUI, rv32d_pkg::OPC_AUIPC: begin
                    kind = (opc == rv32d_pkg::OPC_LUI) ? rv32d_pkg::OP_LUI
                                                       : rv32d_pkg::OP_AUIPC;
                    d.imm = imm_u;
                    d.rd  = w[11:7];
                end
                rv32d_pkg::OPC_JAL: begin
                    kind     = rv32d_pkg::OP_JAL;
                    d.imm    = imm_j;
                    d.rd     = w[11:7];
                    d.target = pc + imm_j;
                end
                rv32d_pkg::OPC_JALR: begin
                    if (f3 == rv32d_pkg::F3_ZERO) begin
                        kind  = rv32d_pkg::OP_JALR;
                        d.imm = imm_i;
                        d.rd  = w[11:7];
                        d.rs1 = w[19:15];
                    end
                end
                rv32d_pkg::OPC_BRANCH: begin
                    case (f3)
                        F3_BEQ:  kind = rv32d_pkg::OP_BEQ;
                        F3_BNE:  kind = rv32d_pkg::OP_BNE;
                        F3_BLT:  kind = rv32d_pkg::OP_BLT;
                        F3_BGE:  kind = rv32d_pkg::OP_BGE;
                        F3_BLTU: kind = rv32d_pkg::OP_BLTU;
                        F3_BGEU: kind = rv32d_pkg::OP_BGEU;
                        default: kind = rv32d_pkg::OP_ILLEGAL;
                    endcase
                    d.imm    = imm_b;
                    d.rs1    = w[19:15];
                    d.rs2    = w[24:20];
                    d.target = pc + imm_b;
                end
                rv32d_pkg::OPC_LOAD: begin
                    case (f3)
                        F3_BYTE:  kind = rv32d_pkg::OP_LB;
                        F3_HALF:  kind = rv32d_pkg::OP_LH;
                        F3_WORD:  kind = rv32d_pkg::OP_LW;
                        F3_BYTEU: kind = rv32d_pkg::OP_LBU;
                        F3_HALFU: kind = rv32d_pkg::OP_LHU;
                        default:  kind = rv32d_pkg::OP_ILLEGAL;
                    endcase
                    d.imm = imm_i;
                    d.rd  = w[11:7];
                    d.rs1 = w[19:15];
                end
                rv32d_pkg::OPC_STORE: begin
                    case (f3)
                        F3_BYTE: kind = rv32d_pkg::OP_SB;
                        F3_HALF: kind = rv32d_pkg::OP_SH;
                        F3_WORD: kind = rv32d_pkg::OP_SW;
                        default: kind = rv32d_pkg::OP_ILLEGAL;
                    endcase
                    d.imm = imm_s;
                    d.rs1 = w[19:15];
                    d.rs2 = w[24:20];
                end
                rv32d_pkg::OPC_ALUI: begin
                    d.rd  = w[11:7];
                    d.rs1 = w[19:15];
                    d.imm = imm_i;
                    case (f3)
                        F3_ADD:  kind = rv32d_pkg::OP_ADDI;
                        F3_SLT:  kind = rv32d_pkg::OP_SLTI;
                        F3_SLTU: kind = rv32d_pkg::OP_SLTIU;
                        F3_XOR:  kind = rv32d_pkg::OP_XORI;
                        F3_OR:   kind = rv32d_pkg::OP_ORI;
                        F3_AND:  kind = rv32d_pkg::OP_ANDI;
                        rv32d_pkg::F3_SLL: begin
                            kind  = (f7 == rv32d_pkg::F7_ZERO) ? rv32d_pkg::OP_SLLI
                                                               : rv32d_pkg::OP_ILLEGAL;
                            d.imm = {{(WORD_BITS-SHAMT_BITS){1'b0}}, w[24:20]};
                        end
                        default: begin
                            // right shifts: funct7 picks logical or arithmetic
                            if (f7 == rv32d_pkg::F7_ZERO)
                                kind = rv32d_pkg::OP_SRLI;
                            else if (f7 == rv32d_pkg::F7_ALT)
                                kind = rv32d_pkg::OP_SRAI;
                            d.imm = {{(WORD_BITS-SHAMT_BITS){1'b0}}, w[24:20]};
                        end
                    endcase
                end
                rv32d_pkg::OPC_ALUR: begin
                    d.rd  = w[11:7];
                    d.rs1 = w[19:15];
                    d.rs2 = w[24:20];
                    if (f7 == rv32d_pkg::F7_ZERO) begin
                        case (f3)
                            F3_ADD:            kind = rv32d_pkg::OP_ADD;
                            rv32d_pkg::F3_SLL: kind = rv32d_pkg::OP_SLL;
                            F3_SLT:            kind = rv32d_pkg::OP_SLT;
                            F3_SLTU:           kind = rv32d_pkg::OP_SLTU;
                            F3_XOR:            kind = rv32d_pkg::OP_XOR;
                            rv32d_pkg::F3_SR:  kind = rv32d_pkg::OP_SRL;
                            F3_OR:             kind = rv32d_pkg::OP_OR;
                            F3_AND:            kind = rv32d_pkg::OP_AND;
                            default:           kind = rv32d_pkg::OP_ILLEGAL;
                        endcase
                    end else if (f7 == rv32d_pkg::F7_ALT && f3 == F3_ADD) begin
                        kind = rv32d_pkg::OP_SUB;
                    end else if (f7 == rv32d_pkg::F7_ALT && f3 == rv32d_pkg::F3_SR) begin
                        kind = rv32d_pkg::OP_SRA;
                    end
                end
                rv32d_pkg::OPC_SYS: begin
                    if (f3 == rv32d_pkg::F3_ZERO) begin
                        // only the two exact words are legal here
                        if (w == rv32d_pkg::ECALL_WORD)
                            kind = rv32d_pkg::OP_ECALL;
                        else if (w == rv32d_pkg::EBREAK_WORD)
                            kind = rv32d_pkg::OP_EBREAK;
                    end else begin
                        case (f3)
                            F3_CSRRW:  kind = rv32d_pkg::OP_CSRRW;
                            F3_CSRRS:  kind = rv32d_pkg::OP_CSRRS;
                            F3_CSRRC:  kind = rv32d_pkg::OP_CSRRC;
                            F3_CSRRWI: kind = rv32d_pkg::OP_CSRRWI;
                            F3_CSRRSI: kind = rv32d_pkg::OP_CSRRSI;
                            F3_CSRRCI: kind = rv32d_pkg::OP_CSRRCI;
                            default:   kind = rv32d_pkg::OP_ILLEGAL;
                        endcase
                        d.rd  = w[11:7];
                        d.rs1 = w[19:15];
                        d.csr = w[31:20];
                    end
                end
                default: kind = rv32d_pkg::OP_ILLEGAL;
            endcase
            // an illegal word carries nothing but the flag
            if (kind == rv32d_pkg::OP_ILLEGAL) begin
                d.rd     = '0;
                d.rs1    = '0;
                d.rs2    = '0;
                d.imm    = '0;
                d.csr    = '0;
                d.target = '0;
            end
            d.kind    = kind;
            d.illegal = (kind == rv32d_pkg::OP_ILLEGAL);
            return d;
        endfunction

        function void note_request(logic [WORD_BITS-1:0] pc, logic [WORD_BITS-1:0] word);
            pending_decodes.push_back(decode_word(pc, word));
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
            if (seen !== want) begin
                errors++;
                $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, seen);
            end
        endfunction

        function void check_result(t_decoded got);
            t_decoded want;
            if (pending_decodes.size() == 0) begin
                errors++;
                $error("decode result with no request outstanding");
                return;
            end
            want = pending_decodes.pop_front();
            results_checked++;
            kinds_seen[int'(want.kind)] = 1'b1;
            compare_field("op_kind", want.kind, got.kind);
            compare_field("illegal", want.illegal, got.illegal);
            compare_field("dest_reg", want.rd, got.rd);
            compare_field("src_reg_a", want.rs1, got.rs1);
            compare_field("src_reg_b", want.rs2, got.rs2);
            compare_field("immediate", want.imm, got.imm);
            compare_field("csr_number", want.csr, got.csr);
            compare_field("target", want.target, got.target);
        endfunction

        function void flag_leftovers();
            if (pending_decodes.size() != 0) begin
                errors += pending_decodes.size();
                $error("%0d requests never produced a result", pending_decodes.size());
            end
        endfunction

        function int kinds_covered();
            int n;
            n = 0;
            foreach (kinds_seen[k])
                if (kinds_seen[k])
                    n++;
            return n;
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n      = 1'b0;
    logic                         i_in_valid   = 1'b0;
    logic [WORD_BITS-1:0]         i_pc         = '0;
    logic [WORD_BITS-1:0]         i_word       = '0;
    logic                         i_out_stall  = 1'b0;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic [KIND_BITS-1:0]         o_op_kind;
    logic                         o_illegal;
    logic [REG_BITS-1:0]          o_dest_reg;
    logic [REG_BITS-1:0]          o_src_reg_a;
    logic [REG_BITS-1:0]          o_src_reg_b;
    logic signed [WORD_BITS-1:0]  o_immediate;
    logic [CSR_BITS-1:0]          o_csr_number;
    logic [WORD_BITS-1:0]         o_target;

    decode_scoreboard decodes = new();
    t_decoded         seen_result;
    int               sent_count    = 0;
    int               results_taken = 0;

    rv32i_instruction_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pc         (i_pc),
        .i_word       (i_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_op_kind    (o_op_kind),
        .o_illegal    (o_illegal),
        .o_dest_reg   (o_dest_reg),
        .o_src_reg_a  (o_src_reg_a),
        .o_src_reg_b  (o_src_reg_b),
        .o_immediate  (o_immediate),
        .o_csr_number (o_csr_number),
        .o_target     (o_target)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Both handshakes are sampled in one place so a request and a result at the
    // same edge are always seen in that order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                decodes.note_request(i_pc, i_word);
            if (o_out_valid && !i_out_stall) begin
                seen_result.kind    = rv32d_pkg::t_op_kind'(o_op_kind);
                seen_result.illegal = o_illegal;
                seen_result.rd      = o_dest_reg;
                seen_result.rs1     = o_src_reg_a;
                seen_result.rs2     = o_src_reg_b;
                seen_result.imm     = o_immediate;
                seen_result.csr     = o_csr_number;
                seen_result.target  = o_target;
                decodes.check_result(seen_result);
            end
        end
    end

    // Result side: random stall before each result, with stall-free stretches.
    initial begin
        int hold;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            hold = (results_taken % 250 >= 200) ? 0 : $urandom_range(0, 10);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            results_taken++;
        end
    end

    // Request side: optional idle gap, then hold the request until taken.
    task automatic send_request(input logic [WORD_BITS-1:0] pc,
                                input logic [WORD_BITS-1:0] word);
        int gap;
        gap = (sent_count % 300 >= 240) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pc       <= pc;
        i_word     <= word;
        do @(posedge i_clk); while (o_in_stall);
        sent_count++;
    endtask

    // Legal encoding of the given kind; all other bits random.
    function automatic logic [WORD_BITS-1:0] encode_op(rv32d_pkg::t_op_kind op);
        logic [WORD_BITS-1:0] w;
        logic [6:0]           opc;
        logic [2:0]           f3;
        logic [6:0]           f7;
        w   = $urandom();
        opc = w[6:0];
        f3  = w[14:12];
        f7  = w[31:25];
        case (op)
            rv32d_pkg::OP_LUI:    opc = rv32d_pkg::OPC_LUI;
            rv32d_pkg::OP_AUIPC:  opc = rv32d_pkg::OPC_AUIPC;
            rv32d_pkg::OP_JAL:    opc = rv32d_pkg::OPC_JAL;
            rv32d_pkg::OP_JALR:   begin opc = rv32d_pkg::OPC_JALR; f3 = rv32d_pkg::F3_ZERO; end
            rv32d_pkg::OP_BEQ:    begin opc = rv32d_pkg::OPC_BRANCH; f3 = F3_BEQ;   end
            rv32d_pkg::OP_BNE:    begin opc = rv32d_pkg::OPC_BRANCH; f3 = F3_BNE;   end
            rv32d_pkg::OP_BLT:    begin opc = rv32d_pkg::OPC_BRANCH; f3 = F3_BLT;   end
            rv32d_pkg::OP_BGE:    begin opc = rv32d_pkg::OPC_BRANCH; f3 = F3_BGE;   end
            rv32d_pkg::OP_BLTU:   begin opc = rv32d_pkg::OPC_BRANCH; f3 = F3_BLTU;  end
            rv32d_pkg::OP_BGEU:   begin opc = rv32d_pkg::OPC_BRANCH; f3 = F3_BGEU;  end
            rv32d_pkg::OP_LB:     begin opc = rv32d_pkg::OPC_LOAD;   f3 = F3_BYTE;  end
            rv32d_pkg::OP_LH:     begin opc = rv32d_pkg::OPC_LOAD;   f3 = F3_HALF;  end
            rv32d_pkg::OP_LW:     begin opc = rv32d_pkg::OPC_LOAD;   f3 = F3_WORD;  end
            rv32d_pkg::OP_LBU:    begin opc = rv32d_pkg::OPC_LOAD;   f3 = F3_BYTEU; end
            rv32d_pkg::OP_LHU:    begin opc = rv32d_pkg::OPC_LOAD;   f3 = F3_HALFU; end
            rv32d_pkg::OP_SB:     begin opc = rv32d_pkg::OPC_STORE;  f3 = F3_BYTE;  end
            rv32d_pkg::OP_SH:     begin opc = rv32d_pkg::OPC_STORE;  f3 = F3_HALF;  end
            rv32d_pkg::OP_SW:     begin opc = rv32d_pkg::OPC_STORE;  f3 = F3_WORD;  end
            rv32d_pkg::OP_ADDI:   begin opc = rv32d_pkg::OPC_ALUI;   f3 = F3_ADD;   end
            rv32d_pkg::OP_SLTI:   begin opc = rv32d_pkg::OPC_ALUI;   f3 = F3_SLT;   end
            rv32d_pkg::OP_SLTIU:  begin opc = rv32d_pkg::OPC_ALUI;   f3 = F3_SLTU;  end
            rv32d_pkg::OP_XORI:   begin opc = rv32d_pkg::OPC_ALUI;   f3 = F3_XOR;   end
            rv32d_pkg::OP_ORI:    begin opc = rv32d_pkg::OPC_ALUI;   f3 = F3_OR;    end
            rv32d_pkg::OP_ANDI:   begin opc = rv32d_pkg::OPC_ALUI;   f3 = F3_AND;   end
            rv32d_pkg::OP_SLLI: begin
                opc = rv32d_pkg::OPC_ALUI; f3 = rv32d_pkg::F3_SLL; f7 = rv32d_pkg::F7_ZERO;
            end
            rv32d_pkg::OP_SRLI: begin
                opc = rv32d_pkg::OPC_ALUI; f3 = rv32d_pkg::F3_SR; f7 = rv32d_pkg::F7_ZERO;
            end
            rv32d_pkg::OP_SRAI: begin
                opc = rv32d_pkg::OPC_ALUI; f3 = rv32d_pkg::F3_SR; f7 = rv32d_pkg::F7_ALT;
            end
            rv32d_pkg::OP_ADD: begin
                opc = rv32d_pkg::OPC_ALUR; f3 = F3_ADD; f7 = rv32d_pkg::F7_ZERO;
            end
            rv32d_pkg::OP_SUB: begin
                opc = rv32d_pkg::OPC_ALUR; f3 = F3_ADD; f7 = rv32d_pkg::F7_ALT;
            end
            rv32d_pkg::OP_SLL: begin
                opc = rv32d_pkg::OPC_ALUR; f3 = rv32d_pkg::F3_SLL; f7 = rv32d_pkg::F7_ZERO;
            end
            rv32d_pkg::OP_SLT: begin
                opc = rv32d_pkg::OPC_ALUR; f3 = F3_SLT; f7 = rv32d_pkg::F7_ZERO;
            end
            rv32d_pkg::OP_SLTU: begin
                opc = rv32d_pkg::OPC_ALUR; f3 = F3_SLTU; f7 = rv32d_pkg::F7_ZERO;
            end
            rv32d_pkg::OP_XOR: begin
                opc = rv32d_pkg::OPC_ALUR; f3 = F3_XOR; f7 = rv32d_pkg::F7_ZERO;
            end
            rv32d_pkg::OP_SRL: begin
                opc = rv32d_pkg::OPC_ALUR; f3 = rv32d_pkg::F3_SR; f7 = rv32d_pkg::F7_ZERO;
            end
            rv32d_pkg::OP_SRA: begin
                opc = rv32d_pkg::OPC_ALUR; f3 = rv32d_pkg::F3_SR; f7 = rv32d_pkg::F7_ALT;
            end
            rv32d_pkg::OP_OR: begin
                opc = rv32d_pkg::OPC_ALUR; f3 = F3_OR; f7 = rv32d_pkg::F7_ZERO;
            end
            rv32d_pkg::OP_AND: begin
                opc = rv32d_pkg::OPC_ALUR; f3 = F3_AND; f7 = rv32d_pkg::F7_ZERO;
            end
            rv32d_pkg::OP_CSRRW:  begin opc = rv32d_pkg::OPC_SYS; f3 = F3_CSRRW;  end
            rv32d_pkg::OP_CSRRS:  begin opc = rv32d_pkg::OPC_SYS; f3 = F3_CSRRS;  end
            rv32d_pkg::OP_CSRRC:  begin opc = rv32d_pkg::OPC_SYS; f3 = F3_CSRRC;  end
            rv32d_pkg::OP_CSRRWI: begin opc = rv32d_pkg::OPC_SYS; f3 = F3_CSRRWI; end
            rv32d_pkg::OP_CSRRSI: begin opc = rv32d_pkg::OPC_SYS; f3 = F3_CSRRSI; end
            rv32d_pkg::OP_CSRRCI: begin opc = rv32d_pkg::OPC_SYS; f3 = F3_CSRRCI; end
            default:   ;
        endcase
        if (op == rv32d_pkg::OP_ECALL)
            return rv32d_pkg::ECALL_WORD;
        if (op == rv32d_pkg::OP_EBREAK)
            return rv32d_pkg::EBREAK_WORD;
        return {f7, w[24:15], f3, w[11:7], opc};
    endfunction

    // Mostly legal words; the rest have a corrupted funct field, are system words with funct3 zero, or are noise.
    function automatic logic [WORD_BITS-1:0] random_word();
        logic [WORD_BITS-1:0] w;
        int                   pick;
        pick = $urandom_range(0, 99);
        w    = encode_op(rv32d_pkg::t_op_kind'($urandom_range(rv32d_pkg::OP_LUI,
                                                              rv32d_pkg::OP_CSRRCI)));
        if (pick >= 96) begin
            w = $urandom();
        end else if (pick >= 92) begin
            // system opcode, funct3 zero; half the time the upper bits are near the ecall/ebreak words
            w[6:0]   = rv32d_pkg::OPC_SYS;
            w[14:12] = rv32d_pkg::F3_ZERO;
            if ($urandom_range(0, 1))
                w[31:7] = {10'd0, 2'($urandom_range(0, 3)), 13'd0};
        end else if (pick >= 80) begin
            if ($urandom_range(0, 1))
                w[14:12] = 3'($urandom());
            else
                w[31:25] = 7'($urandom());
        end
        return w;
    endfunction

    task automatic send_directed();
        logic [WORD_BITS-1:0] pcs   [25];
        logic [WORD_BITS-1:0] words [25];
        pcs   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFC,
                  32'h1234_5678, 32'h8000_0000, 32'h0000_0100, 32'h0000_0200,
                  32'h0000_0300, 32'h0000_0400, 32'h0000_0500, 32'h7FFF_FFFC,
                  32'h0000_0600, 32'h0000_0700, 32'h0000_0800, 32'h0000_0000,
                  32'hFFFF_FFFF, 32'h0000_0010, 32'hFFFF_FFF0, 32'hAAAA_AAAA,
                  32'h5555_5554, 32'h0000_0900, 32'hFFFF_F000, 32'h0000_0A00,
                  32'h0000_0B00};
        words = '{32'h0000_0000,   // all zero: illegal
                  32'hFFFF_FFFF,   // all ones: unknown opcode
                  rv32d_pkg::ECALL_WORD,
                  rv32d_pkg::EBREAK_WORD,
                  32'h0020_0073,   // system funct3 zero, neither ecall nor ebreak
                  32'hFFFF_CFF3,   // system funct3 four
                  32'h0000_1067,   // jalr with nonzero funct3
                  32'h0000_2063,   // branch, unknown funct3
                  32'h0000_3003,   // load, unknown funct3
                  32'h0000_7023,   // store, unknown funct3
                  32'h0200_1013,   // slli with nonzero funct7
                  32'h41FF_DF93,   // srai x31, x31, 31
                  32'h0200_0033,   // add with funct7 one
                  32'h41FF_8FB3,   // sub x31, x31, x31
                  32'h4031_50B3,   // sra x1, x2, x3
                  32'h8000_0063,   // beq, most negative offset, target wraps
                  32'h7E00_7FE3,   // bgeu, largest offset, target wraps
                  32'h8000_006F,   // jal, most negative offset
                  32'h7FFF_FFEF,   // jal x31, largest offset, target wraps
                  32'hFFFF_FFB7,   // lui x31 with all upper bits set
                  32'h8000_0013,   // addi, most negative immediate
                  32'hFFFF_FF93,   // andi x31, x31, -1
                  32'hFFFF_FFF3,   // csrrci, csr 0xfff, zimm 31
                  32'hFE00_2FA3,   // sw with offset -1
                  32'h0010_00F3};  // ebreak pattern with rd set: illegal
        foreach (words[k])
            send_request(pcs[k], words[k]);
    endtask

    initial begin
        logic [WORD_BITS-1:0] pc;
        int                   drain;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_directed();
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pc = $urandom();
            // pull some addresses next to zero or the top so targets wrap
            if ($urandom_range(0, 3) == 0)
                pc[31:12] = {20{pc[31]}};
            send_request(pc, random_word());
        end
        i_in_valid <= 1'b0;

        drain = 0;
        while (decodes.pending_decodes.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        decodes.flag_leftovers();

        $display("Covered %0d requests (corner words, then random); %0d results checked.",
                 sent_count, decodes.results_checked);
        $display("Distinct op kinds seen, illegal included: %0d of 46.",
                 decodes.kinds_covered());
        if (decodes.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[rv32i_instruction_decoder.f]
+incdir+src
src/rv32d_pkg.sv
src/rv32i_instruction_decoder.sv
dv/tb_rv32i_instruction_decoder.sv
